// ===== design/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks prop at every rising clock edge outside reset.
`define B2N_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("b2n assertion failed");
// Checks that cons holds in the cycle after ante.
`define B2N_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b2n assertion failed");
`else
`define B2N_ASSERT(lbl, prop)
`define B2N_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/b2n_pkg.sv =====
// Package for the BGRA to NV12 pixel converter: shared types, register codes,
// BT.601 weights and defaults. Depends on nothing.
package b2n_pkg;

    localparam int DEFAULT_MAX_DIMENSION = 4096;
    localparam int DEFAULT_FRAME_WIDTH   = 1920;
    localparam int DEFAULT_FRAME_HEIGHT  = 1080;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int POS_W       = 12;
    localparam int PIX_W       = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Depth of each of the two internal queues; a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Fixed-point weights, scaled by 256.
    localparam int SUM_W       = 17;
    localparam int Y_R         = 66;
    localparam int Y_G         = 129;
    localparam int Y_B         = 25;
    localparam int CB_R        = 38;
    localparam int CB_G        = 74;
    localparam int CB_B        = 112;
    localparam int CR_R        = 112;
    localparam int CR_G        = 94;
    localparam int CR_B        = 18;
    localparam int ROUND       = 128;
    // Rounding term plus 128 << 8, which moves the chroma sums into positive range.
    localparam int CHROMA_BIAS = 32896;
    localparam int LUMA_OFFSET = 16;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             chroma_valid;
        logic             frame_end;
    } front_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             frame_end;
    } out_item_t;

endpackage

// ===== design/bgra_to_nv12_pixel_converter_core.sv =====
// Top level of the BGRA to NV12 pixel converter.
// Depends on b2n_pkg, b2n_queue, b2n_front, b2n_back and assert_macros.svh.
//
// Usage:
// Pixels arrive in raster order on blue, green and red (alpha is not carried).
// A request is taken at a rising edge with push high and full low. Each pixel
// yields exactly one result: BT.601 luma, chroma taken from the pixel at an
// even column and even row (zero elsewhere), its position and an end-of-frame
// mark. The oldest result is shown while empty is low and leaves on pop.
// Frame size is written on the cfg channel (index 0 width, index 1 height)
// while no pixel is in flight; cfg_ready is always high. Sizes of zero act as
// one and sizes above MAX_DIMENSION act as MAX_DIMENSION.
// Timing: the front end classifies a pixel in the cycle it is taken and puts
// it into a four-entry queue; the back end computes one pixel a cycle from that
// queue into a four-entry result queue while that queue has room. A result is
// shown once it is in the result queue, having passed the middle queue first.
// One pixel per cycle is sustained while pop stays high, since each queue
// moves one entry a cycle and the back end is a single combinational pass.
// When the receiver stalls, the result queue fills, then the middle queue, and
// full rises once eight pixels wait; nothing is lost. Reset clears both queues
// and the position counters and restores 1920 by 1080.
`include "assert_macros.svh"

module bgra_to_nv12_pixel_converter_core
    import b2n_pkg::*;
#(
    parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [PIX_W-1:0]       blue,
    input  logic [PIX_W-1:0]       green,
    input  logic [PIX_W-1:0]       red,
    output logic                   empty,
    input  logic                   pop,
    output logic [PIX_W-1:0]       luma,
    output logic                   chroma_valid,
    output logic [PIX_W-1:0]       chroma_blue,
    output logic [PIX_W-1:0]       chroma_red,
    output logic [POS_W-1:0]       column,
    output logic [POS_W-1:0]       row,
    output logic                   frame_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W    = $clog2(MAX_DIMENSION);
    localparam int DIM_W    = CNT_W + 1;
    localparam int CMP_W    = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
    localparam int FRONT_W  = $bits(front_item_t);
    localparam int OUT_W    = $bits(out_item_t);
    localparam int RST_W_INT = (DEFAULT_FRAME_WIDTH > MAX_DIMENSION) ?
                               MAX_DIMENSION : DEFAULT_FRAME_WIDTH;
    localparam int RST_H_INT = (DEFAULT_FRAME_HEIGHT > MAX_DIMENSION) ?
                               MAX_DIMENSION : DEFAULT_FRAME_HEIGHT;
    localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_DIMENSION);

    // Effective frame size, clamped once when written.
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [CMP_W-1:0] cfg_ext;
    logic [DIM_W-1:0] size_eff;

    logic        in_accept;
    front_item_t front_item;
    logic        mid_full, mid_empty, mid_move;
    logic [FRONT_W-1:0] mid_rdata;
    front_item_t mid_item;
    out_item_t   back_result;
    logic        out_full, out_empty, out_pop;
    logic [OUT_W-1:0] out_rdata;
    out_item_t   out_item;

    assign cfg_ready = 1'b1;
    assign cfg_ext   = CMP_W'(cfg_data);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            size_eff = DIM_W'(1);
        end
        else if (cfg_ext > MAX_EXT)
        begin
            size_eff = DIM_W'(MAX_DIMENSION);
        end
        else
        begin
            size_eff = DIM_W'(cfg_ext);
        end
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = size_eff;
                REG_FRAME_HEIGHT: height_next = size_eff;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(RST_W_INT);
            height_reg <= DIM_W'(RST_H_INT);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Front end: a request is taken whenever the middle queue has room.
    assign full      = mid_full;
    assign in_accept = push && !mid_full;

    b2n_front #(
        .MAX_DIMENSION(MAX_DIMENSION),
        .CNT_W        (CNT_W),
        .DIM_W        (DIM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .width_eff (width_reg),
        .height_eff(height_reg),
        .item      (front_item)
    );

    b2n_queue #(
        .WIDTH(FRONT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_mid_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (in_accept),
        .wr_data(front_item),
        .full   (mid_full),
        .rd_en  (mid_move),
        .rd_data(mid_rdata),
        .empty  (mid_empty)
    );

    // Back end: one pixel moves from the middle queue into the result queue
    // in every cycle that both sides allow.
    assign mid_item = front_item_t'(mid_rdata);
    assign mid_move = !mid_empty && !out_full;

    b2n_back u_back (
        .item  (mid_item),
        .result(back_result)
    );

    b2n_queue #(
        .WIDTH(OUT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (mid_move),
        .wr_data(back_result),
        .full   (out_full),
        .rd_en  (out_pop),
        .rd_data(out_rdata),
        .empty  (out_empty)
    );

    assign out_pop  = pop && !out_empty;
    assign out_item = out_item_t'(out_rdata);

    assign empty        = out_empty;
    assign luma         = out_item.luma;
    assign chroma_valid = out_item.chroma_valid;
    assign chroma_blue  = out_item.chroma_blue;
    assign chroma_red   = out_item.chroma_red;
    assign column       = out_item.column;
    assign row          = out_item.row;
    assign frame_end    = out_item.frame_end;

    // A shown luma always lies in the studio range.
    `B2N_ASSERT(a_luma_range, !empty |-> (luma >= 8'd16 && luma <= 8'd235))
    // Chroma is only produced at even positions and is zero elsewhere.
    `B2N_ASSERT(a_chroma_even, (!empty && chroma_valid) |-> (!column[0] && !row[0]))
    `B2N_ASSERT(a_chroma_zero,
        (!empty && !chroma_valid) |-> (chroma_blue == 8'd0 && chroma_red == 8'd0))
    // A pixel taken into an empty pipeline is shown after moving through both queues.
    `B2N_ASSERT_NEXT(a_latency, (in_accept && mid_empty && out_empty), ##1 !empty)

endmodule

// ===== design/b2n_queue.sv =====
// Small first-in first-out queue built from registers.
// Depends on nothing; the caller gates writes with full and reads with empty.
module b2n_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

endmodule

// ===== design/b2n_front.sv =====
// Front end of the converter: tracks column and row and classifies each pixel.
// Depends on b2n_pkg.
module b2n_front
    import b2n_pkg::*;
#(
    parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION,
    parameter int CNT_W         = $clog2(MAX_DIMENSION),
    parameter int DIM_W         = CNT_W + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [PIX_W-1:0] blue,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] red,
    input  logic [DIM_W-1:0] width_eff,
    input  logic [DIM_W-1:0] height_eff,
    output front_item_t      item
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] col_plus;
    logic [DIM_W-1:0] row_plus;
    logic             last_col;
    logic             last_row;

    assign col_plus = {1'b0, col_reg} + DIM_W'(1);
    assign row_plus = {1'b0, row_reg} + DIM_W'(1);
    assign last_col = (col_plus >= width_eff);
    assign last_row = (row_plus >= height_eff);

    always_comb
    begin
        item.blue         = blue;
        item.green        = green;
        item.red          = red;
        item.column       = POS_W'(col_reg);
        item.row          = POS_W'(row_reg);
        item.chroma_valid = !col_reg[0] && !row_reg[0];
        item.frame_end    = last_col && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : CNT_W'(row_plus);
            end
            else
            begin
                col_next = CNT_W'(col_plus);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== design/b2n_back.sv =====
// Back end of the converter: BT.601 fixed-point luma and chroma for one pixel.
// Depends on b2n_pkg.
module b2n_back
    import b2n_pkg::*;
(
    input  front_item_t item,
    output out_item_t   result
);

    logic [SUM_W-1:0] r_ext, g_ext, b_ext;
    logic [SUM_W-1:0] y_sum, cb_sum, cr_sum;

    assign r_ext = SUM_W'(item.red);
    assign g_ext = SUM_W'(item.green);
    assign b_ext = SUM_W'(item.blue);

    // Chroma sums carry a bias of 128 << 8, so bits 15:8 are already the offset sample.
    assign y_sum  = SUM_W'(Y_R) * r_ext + SUM_W'(Y_G) * g_ext + SUM_W'(Y_B) * b_ext
                  + SUM_W'(ROUND);
    assign cb_sum = SUM_W'(CB_B) * b_ext + SUM_W'(CHROMA_BIAS)
                  - SUM_W'(CB_R) * r_ext - SUM_W'(CB_G) * g_ext;
    assign cr_sum = SUM_W'(CR_R) * r_ext + SUM_W'(CHROMA_BIAS)
                  - SUM_W'(CR_G) * g_ext - SUM_W'(CR_B) * b_ext;

    always_comb
    begin
        result.luma         = y_sum[15:8] + PIX_W'(LUMA_OFFSET);
        result.chroma_valid = item.chroma_valid;
        result.chroma_blue  = item.chroma_valid ? cb_sum[15:8] : '0;
        result.chroma_red   = item.chroma_valid ? cr_sum[15:8] : '0;
        result.column       = item.column;
        result.row          = item.row;
        result.frame_end    = item.frame_end;
    end

endmodule
